### rtl/sebg_pkg.sv
// sebg_pkg: shared widths, register reset values and output limits for the
// spectral equaliser bin gain block. No dependencies.

package sebg_pkg;

   localparam int LOG2_BINS_DEFAULT = 9;
   localparam int NUM_BANDS         = 8;
   localparam int BAND_W            = 3;
   localparam int GAIN_W            = 17;
   localparam int GAIN_FRAC_BITS    = 14;
   localparam int MAG_W             = 24;
   localparam int PHASE_W           = 16;
   localparam int OUT_W             = 28;
   localparam int CSR_INDEX_W       = 4;

   localparam logic [GAIN_W-1:0]       GAIN_RESET = GAIN_W'(16384);
   localparam logic signed [OUT_W-1:0] OUT_MAX    = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN    = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

### rtl/spectral_eq_bin_gain.sv
// spectral_eq_bin_gain: eight-band graphic equaliser gain per spectrum bin.
// Pipeline: input register, one square-root stage per result bit, then the
// coefficient, Horner, polynomial, product and output registers.
// Throughput: one item per cycle; busy is never raised, results cannot stall.
// Reset clears all stage valid bits and sets every band gain to 1.0.
// Depends on sebg_pkg.

module spectral_eq_bin_gain #(
   parameter int LOG2_BINS = sebg_pkg::LOG2_BINS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [LOG2_BINS-1:0]                   req_bin_index,
   input  logic [sebg_pkg::MAG_W-1:0]             req_magnitude,
   input  logic signed [sebg_pkg::PHASE_W-1:0]    req_phase,
   output logic                                   rsp_valid,
   output logic signed [sebg_pkg::OUT_W-1:0]      rsp_scaled_magnitude,
   output logic signed [sebg_pkg::PHASE_W-1:0]    rsp_phase_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sebg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sebg_pkg::GAIN_W-1:0]            csr_wdata
);

   localparam int L       = LOG2_BINS;
   localparam int F       = L - 3;
   localparam int SW      = 2 * L;
   localparam int CW      = 22;
   localparam int H1W     = CW + F + 1;
   localparam int H2W     = H1W + F + 1;
   localparam int PW      = H2W + F + 1;
   localparam int GW      = PW - 3 * F - 1;
   localparam int PRW     = sebg_pkg::MAG_W + 1 + GW;
   localparam int LATENCY = L + 6;
   localparam int SAT_LO  = sebg_pkg::GAIN_FRAC_BITS + sebg_pkg::OUT_W - 1;

   // band gain registers
   logic [sebg_pkg::GAIN_W-1:0] gain_ff [sebg_pkg::NUM_BANDS];

   // square-root stages, index 0 is the input register
   logic [SW-1:0]                      sq_rem_ff   [0:L];
   logic [SW-1:0]                      sq_rem_in   [0:L];
   logic [L-1:0]                       sq_root_ff  [0:L];
   logic [L-1:0]                       sq_root_in  [0:L];
   logic [SW:0]                        sq_trial    [0:L-1];
   logic                               sq_vld_ff   [0:L];
   logic [sebg_pkg::MAG_W-1:0]         sq_mag_ff   [0:L];
   logic signed [sebg_pkg::PHASE_W-1:0] sq_phase_ff [0:L];

   // coefficient stage
   logic [sebg_pkg::BAND_W-1:0] band;
   logic [sebg_pkg::BAND_W-1:0] bsel0, bsel1, bsel3;
   logic signed [CW-1:0]        g0_s, g1_s, g2_s, g3_s;
   logic signed [CW-1:0]        ca_in, cb_in, cc_in;
   logic signed [CW-1:0]        ca_ff, cb_ff, cc_ff;
   logic [sebg_pkg::GAIN_W-1:0] c_g1_ff;
   logic [F-1:0]                c_t_ff;
   logic                        c_vld_ff;
   logic [sebg_pkg::MAG_W-1:0]  c_mag_ff;
   logic signed [sebg_pkg::PHASE_W-1:0] c_phase_ff;

   // Horner stages
   logic signed [CW+F:0]        h1_prod;
   logic signed [H1W-1:0]       h1_in, h1_ff;
   logic signed [CW-1:0]        h1_ca_ff;
   logic [sebg_pkg::GAIN_W-1:0] h1_g1_ff;
   logic [F-1:0]                h1_t_ff;
   logic                        h1_vld_ff;
   logic [sebg_pkg::MAG_W-1:0]  h1_mag_ff;
   logic signed [sebg_pkg::PHASE_W-1:0] h1_phase_ff;

   logic signed [H2W-1:0]       h2_prod;
   logic signed [H2W-1:0]       h2_in, h2_ff;
   logic [sebg_pkg::GAIN_W-1:0] h2_g1_ff;
   logic [F-1:0]                h2_t_ff;
   logic                        h2_vld_ff;
   logic [sebg_pkg::MAG_W-1:0]  h2_mag_ff;
   logic signed [sebg_pkg::PHASE_W-1:0] h2_phase_ff;

   logic signed [PW-1:0]        p_prod;
   logic signed [PW-1:0]        p_in, p_ff;
   logic                        p_vld_ff;
   logic [sebg_pkg::MAG_W-1:0]  p_mag_ff;
   logic signed [sebg_pkg::PHASE_W-1:0] p_phase_ff;

   // magnitude product and output stage
   logic signed [GW-1:0]        gain_q;
   logic signed [PRW-1:0]       prod_in, prod_ff;
   logic                        prod_vld_ff;
   logic signed [sebg_pkg::PHASE_W-1:0] prod_phase_ff;
   logic [PRW-SAT_LO-1:0]       prod_hi;
   logic signed [sebg_pkg::OUT_W-1:0] out_in, out_ff;
   logic                        out_vld_ff;
   logic signed [sebg_pkg::PHASE_W-1:0] out_phase_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // integer square root, one result bit per stage
   always_comb begin
      sq_rem_in[0]  = {req_bin_index, L'(0)};
      sq_root_in[0] = '0;
      for (int k = 0; k < L; k++) begin
         sq_trial[k] = ((SW+1)'(sq_root_ff[k]) << (L - k))
                     + ((SW+1)'(1) << (2 * (L - 1 - k)));
         if ({1'b0, sq_rem_ff[k]} >= sq_trial[k]) begin
            sq_rem_in[k+1]  = sq_rem_ff[k] - sq_trial[k][SW-1:0];
            sq_root_in[k+1] = sq_root_ff[k] | (L'(1) << (L - 1 - k));
         end else begin
            sq_rem_in[k+1]  = sq_rem_ff[k];
            sq_root_in[k+1] = sq_root_ff[k];
         end
      end
   end

   // band selection with clamping, spline coefficients
   always_comb begin
      band  = sq_root_ff[L][L-1 -: sebg_pkg::BAND_W];
      bsel0 = (band < sebg_pkg::BAND_W'(2)) ? '0 : band - sebg_pkg::BAND_W'(2);
      bsel1 = (band == '0) ? '0 : band - sebg_pkg::BAND_W'(1);
      bsel3 = (band == '1) ? '1 : band + sebg_pkg::BAND_W'(1);
      g0_s  = $signed(CW'(gain_ff[bsel0]));
      g1_s  = $signed(CW'(gain_ff[bsel1]));
      g2_s  = $signed(CW'(gain_ff[band]));
      g3_s  = $signed(CW'(gain_ff[bsel3]));
      ca_in = g2_s - g0_s;
      cb_in = (g0_s <<< 1) - (g1_s <<< 2) - g1_s + (g2_s <<< 2) - g3_s;
      cc_in = g3_s - g0_s + (g1_s <<< 1) + g1_s - (g2_s <<< 1) - g2_s;
   end

   assign h1_prod = cc_ff * $signed({1'b0, c_t_ff});
   assign h1_in   = (H1W'(cb_ff) <<< F) + H1W'(h1_prod);

   assign h2_prod = h1_ff * $signed({1'b0, h1_t_ff});
   assign h2_in   = (H2W'(h1_ca_ff) <<< (2 * F)) + h2_prod;

   assign p_prod  = h2_ff * $signed({1'b0, h2_t_ff});
   assign p_in    = ($signed(PW'(h2_g1_ff)) <<< (3 * F + 1)) + p_prod;

   // floor by 2^(3F+1) is a plain slice of the two's complement value
   assign gain_q  = p_ff[PW-1 : 3*F+1];
   assign prod_in = $signed({1'b0, p_mag_ff}) * gain_q;

   always_comb begin
      prod_hi = prod_ff[PRW-1:SAT_LO];
      if ((&prod_hi) || !(|prod_hi)) begin
         out_in = prod_ff[SAT_LO:sebg_pkg::GAIN_FRAC_BITS];
      end else if (prod_ff[PRW-1]) begin
         out_in = sebg_pkg::OUT_MIN;
      end else begin
         out_in = sebg_pkg::OUT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < sebg_pkg::NUM_BANDS; b++) begin
            gain_ff[b] <= sebg_pkg::GAIN_RESET;
         end
         for (int k = 0; k <= L; k++) begin
            sq_vld_ff[k] <= 1'b0;
         end
         c_vld_ff    <= 1'b0;
         h1_vld_ff   <= 1'b0;
         h2_vld_ff   <= 1'b0;
         p_vld_ff    <= 1'b0;
         prod_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready &&
             csr_index < sebg_pkg::CSR_INDEX_W'(sebg_pkg::NUM_BANDS)) begin
            gain_ff[csr_index[sebg_pkg::BAND_W-1:0]] <= csr_wdata;
         end
         sq_vld_ff[0] <= start && !busy;
         for (int k = 0; k < L; k++) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
         c_vld_ff    <= sq_vld_ff[L];
         h1_vld_ff   <= c_vld_ff;
         h2_vld_ff   <= h1_vld_ff;
         p_vld_ff    <= h2_vld_ff;
         prod_vld_ff <= p_vld_ff;
         out_vld_ff  <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_rem_ff[0]   <= sq_rem_in[0];
      sq_root_ff[0]  <= sq_root_in[0];
      sq_mag_ff[0]   <= req_magnitude;
      sq_phase_ff[0] <= req_phase;
      for (int k = 0; k < L; k++) begin
         sq_rem_ff[k+1]   <= sq_rem_in[k+1];
         sq_root_ff[k+1]  <= sq_root_in[k+1];
         sq_mag_ff[k+1]   <= sq_mag_ff[k];
         sq_phase_ff[k+1] <= sq_phase_ff[k];
      end

      ca_ff      <= ca_in;
      cb_ff      <= cb_in;
      cc_ff      <= cc_in;
      c_g1_ff    <= gain_ff[bsel1];
      c_t_ff     <= sq_root_ff[L][F-1:0];
      c_mag_ff   <= sq_mag_ff[L];
      c_phase_ff <= sq_phase_ff[L];

      h1_ff       <= h1_in;
      h1_ca_ff    <= ca_ff;
      h1_g1_ff    <= c_g1_ff;
      h1_t_ff     <= c_t_ff;
      h1_mag_ff   <= c_mag_ff;
      h1_phase_ff <= c_phase_ff;

      h2_ff       <= h2_in;
      h2_g1_ff    <= h1_g1_ff;
      h2_t_ff     <= h1_t_ff;
      h2_mag_ff   <= h1_mag_ff;
      h2_phase_ff <= h1_phase_ff;

      p_ff        <= p_in;
      p_mag_ff    <= h2_mag_ff;
      p_phase_ff  <= h2_phase_ff;

      prod_ff       <= prod_in;
      prod_phase_ff <= p_phase_ff;

      out_ff       <= out_in;
      out_phase_ff <= prod_phase_ff;
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_scaled_magnitude = out_ff;
   assign rsp_phase_out        = out_phase_ff;

`ifndef ASSERT_OFF
   // result is sampled at the edge after the one that raises rsp_valid
   a_item_emerges: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(LATENCY + 1) rsp_valid)
      else $error("accepted item did not produce a result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY + 1))
      else $error("result without a matching item");

   a_sqrt_exact: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[L] |-> ({1'b0, sq_rem_ff[L]} <= (SW+1)'({sq_root_ff[L], 1'b0})))
      else $error("square root remainder out of range");
`endif

endmodule

### bench/testbench.sv
// testbench: self-checking bench for spectral_eq_bin_gain. It predicts the gain, scaled
// magnitude and phase for each bin, then compares every result in order.
// Depends on sebg_pkg and the spectral_eq_bin_gain RTL only.

module testbench;

   localparam int LOG2_BINS   = sebg_pkg::LOG2_BINS_DEFAULT;
   localparam int FRAC_W      = LOG2_BINS - 3;
   localparam int LATENCY     = LOG2_BINS + 6;
   localparam int STALL_LIMIT = 2000;
   localparam int CHUNK_BINS  = 58;

   localparam logic [sebg_pkg::CSR_INDEX_W-1:0] CSR_GAIN_BAND_0 = 4'd0;
   localparam logic [sebg_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_0    = 4'd8;

   typedef struct packed {
      logic signed [sebg_pkg::OUT_W-1:0]   scaled;
      logic signed [sebg_pkg::PHASE_W-1:0] phase;
   } bin_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic [LOG2_BINS-1:0]                 req_bin_index = '0;
   logic [sebg_pkg::MAG_W-1:0]           req_magnitude = '0;
   logic signed [sebg_pkg::PHASE_W-1:0]  req_phase = '0;
   logic                                 rsp_valid;
   logic signed [sebg_pkg::OUT_W-1:0]    rsp_scaled_magnitude;
   logic signed [sebg_pkg::PHASE_W-1:0]  rsp_phase_out;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [sebg_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [sebg_pkg::GAIN_W-1:0]          csr_wdata = '0;

   logic [sebg_pkg::GAIN_W-1:0] band_gain [sebg_pkg::NUM_BANDS];
   bin_result_type    pending_bins [$];
   int                sender_idle_pct = 0;
   int                mismatches = 0;
   int                bins_sent = 0;
   int                results_seen = 0;
   int                csr_writes = 0;
   int                idle_cycles = 0;

   spectral_eq_bin_gain u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_bin_index        (req_bin_index),
      .req_magnitude        (req_magnitude),
      .req_phase            (req_phase),
      .rsp_valid            (rsp_valid),
      .rsp_scaled_magnitude (rsp_scaled_magnitude),
      .rsp_phase_out        (rsp_phase_out),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      for (int b = 0; b < sebg_pkg::NUM_BANDS; b++) band_gain[b] = sebg_pkg::GAIN_RESET;
   end

   // exact floor(sqrt(bin * BINS))
   function automatic int unsigned warped_index(input logic [LOG2_BINS-1:0] bin);
      int unsigned x;
      int unsigned root;
      int unsigned trial;
      x = int'(bin) << LOG2_BINS;
      root = 0;
      for (int k = LOG2_BINS - 1; k >= 0; k--) begin
         trial = root | (32'd1 << k);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   function automatic longint clamped_gain(input int band);
      if (band < 0) band = 0;
      if (band > sebg_pkg::NUM_BANDS - 1) band = sebg_pkg::NUM_BANDS - 1;
      return longint'(band_gain[band]);
   endfunction

   function automatic logic signed [sebg_pkg::OUT_W-1:0] equalised_magnitude(
      input logic [LOG2_BINS-1:0] bin, input logic [sebg_pkg::MAG_W-1:0] mag);
      int unsigned w;
      int          band;
      longint      t, s, g0, g1, g2, g3, ca, cb, cc, poly, gain, m, scaled;
      w    = warped_index(bin);
      band = int'(w >> FRAC_W);
      t    = longint'(w & ((1 << FRAC_W) - 1));
      s    = longint'(1) << FRAC_W;
      g0   = clamped_gain(band - 2);
      g1   = clamped_gain(band - 1);
      g2   = clamped_gain(band);
      g3   = clamped_gain(band + 1);
      ca   = g2 - g0;
      cb   = 2 * g0 - 5 * g1 + 4 * g2 - g3;
      cc   = -g0 + 3 * g1 - 3 * g2 + g3;
      poly = 2 * g1 * s * s * s + ca * t * s * s + cb * t * t * s + cc * t * t * t;
      gain = poly >>> (3 * FRAC_W + 1);
      m    = mag;
      scaled = (m * gain) >>> sebg_pkg::GAIN_FRAC_BITS;
      if (scaled > sebg_pkg::OUT_MAX) scaled = sebg_pkg::OUT_MAX;
      if (scaled < sebg_pkg::OUT_MIN) scaled = sebg_pkg::OUT_MIN;
      return scaled[sebg_pkg::OUT_W-1:0];
   endfunction

   task automatic note_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
   endtask

   // result checker
   always @(posedge clock) begin
      bin_result_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_bins.size() == 0) begin
            note_mismatch("unexpected item", 0, rsp_scaled_magnitude);
         end else begin
            want = pending_bins.pop_front();
            if (rsp_scaled_magnitude !== want.scaled)
               note_mismatch("scaled_magnitude", want.scaled, rsp_scaled_magnitude);
            if (rsp_phase_out !== want.phase)
               note_mismatch("phase_out", want.phase, rsp_phase_out);
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d items pending", $time,
                     STALL_LIMIT, pending_bins.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_bin(input logic [LOG2_BINS-1:0] bin,
                           input logic [sebg_pkg::MAG_W-1:0] mag,
                           input logic signed [sebg_pkg::PHASE_W-1:0] ph);
      bin_result_type want;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_bin_index <= bin;
      req_magnitude <= mag;
      req_phase     <= ph;
      do @(posedge clock); while (busy);
      want.scaled = equalised_magnitude(bin, mag);
      want.phase  = ph;
      pending_bins.push_back(want);
      bins_sent++;
   endtask

   task automatic write_csr(input logic [sebg_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sebg_pkg::GAIN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < CSR_UNUSED_0) band_gain[idx - CSR_GAIN_BAND_0] = value;
      csr_writes++;
   endtask

   // gains given band 7 down to band 0
   task automatic load_gains(
      input logic [sebg_pkg::NUM_BANDS-1:0][sebg_pkg::GAIN_W-1:0] gains);
      for (int b = 0; b < sebg_pkg::NUM_BANDS; b++)
         write_csr(CSR_GAIN_BAND_0 + sebg_pkg::CSR_INDEX_W'(b), gains[b]);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   function automatic logic [sebg_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(9))
         0: return '0;
         1: return sebg_pkg::GAIN_RESET;
         2: return sebg_pkg::GAIN_W'(65536);
         3: return '1;
         4, 5: return sebg_pkg::GAIN_W'($urandom_range(131071));
         default: return sebg_pkg::GAIN_W'($urandom_range(65536));
      endcase
   endfunction

   function automatic logic [sebg_pkg::MAG_W-1:0] pick_magnitude();
      case ($urandom_range(4))
         0: return sebg_pkg::MAG_W'($urandom_range(255));
         1: return {4'hF, 20'($urandom)};
         default: return sebg_pkg::MAG_W'($urandom);
      endcase
   endfunction

   task automatic test_unity_gain();
      send_bin(9'd0, 24'd0, -16'sd32768);
      send_bin(9'd511, 24'hFFFFFF, 16'sd32767);
      send_bin(9'd1, 24'd1, 16'sd0);
      send_bin(9'd256, 24'h800000, -16'sd1);
      send_bin(9'd128, 24'h123456, 16'sh5555);
      wait_idle();
   endtask

   // first bin of each band, plus the ends of band 0 and band 7
   task automatic test_band_sweep();
      load_gains({17'd40000, 17'd12345, 17'd131071, 17'd50000,
                  17'd0, 17'd65536, 17'd30000, 17'd2000});
      for (int k = 0; k < sebg_pkg::NUM_BANDS; k++)
         send_bin(LOG2_BINS'(8 * k * k), 24'hFFFFFF - sebg_pkg::MAG_W'(k),
                  sebg_pkg::PHASE_W'(k * 4099));
      send_bin(9'd7, 24'hABCDEF, 16'sh2AAA);
      send_bin(9'd511, 24'hFFFFFF, -16'sd2);
      wait_idle();
   endtask

   // spline bulge above full scale saturates; dip below zero goes negative
   task automatic test_spline_overshoot();
      load_gains({17'd0, 17'd0, 17'd0, 17'd131071, 17'd131071, 17'd0, 17'd0, 17'd0});
      send_bin(9'd162, 24'hFFFFFF, 16'sd100);
      send_bin(9'd162, 24'd0, -16'sd100);
      wait_idle();
      load_gains({17'd0, 17'd0, 17'd131071, 17'd0, 17'd0, 17'd131071, 17'd0, 17'd0});
      send_bin(9'd162, 24'hFFFFFF, 16'sd7);
      send_bin(9'd150, 24'h00F00F, -16'sd7);
      wait_idle();
   endtask

   task automatic test_unused_registers();
      for (int r = CSR_UNUSED_0; r < 2 ** sebg_pkg::CSR_INDEX_W; r++)
         write_csr(sebg_pkg::CSR_INDEX_W'(r), sebg_pkg::GAIN_W'($urandom));
      csr_valid <= 1'b0;
      send_bin(9'd300, 24'h7FFFFF, 16'sh1234);
      send_bin(9'd40, 24'h00FFFF, -16'sh1234);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int profile [3] = '{26, 55, 0};
      logic [sebg_pkg::NUM_BANDS-1:0][sebg_pkg::GAIN_W-1:0] gains;
      for (int p = 0; p < 3; p++) begin
         sender_idle_pct = profile[p];
         for (int c = 0; c < 4; c++) begin
            for (int b = 0; b < sebg_pkg::NUM_BANDS; b++) gains[b] = pick_gain();
            if ($urandom_range(1)) begin
               write_csr(sebg_pkg::CSR_INDEX_W'($urandom_range(15, CSR_UNUSED_0)),
                         sebg_pkg::GAIN_W'($urandom));
            end
            load_gains(gains);
            repeat (CHUNK_BINS)
               send_bin(LOG2_BINS'($urandom), pick_magnitude(),
                        sebg_pkg::PHASE_W'($urandom));
            wait_idle();
         end
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unity_gain();
      test_band_sweep();
      test_spline_overshoot();
      test_unused_registers();
      test_random_traffic();
      if (pending_bins.size() != 0) begin
         $display("%0d items never returned", pending_bins.size());
         mismatches += pending_bins.size();
      end
      $display("Covered %0d bins and %0d results over %0d register writes,", bins_sent,
               results_seen, csr_writes);
      $display("with unity, extreme and random band gains at three sender idle rates.");
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
